@@ rtl/core/hpd_pkg.sv @@
// Shared types and constants for the hybrid packet deframer.
// No dependencies; used by hpd_step and hybrid_packet_deframer.
package hpd_pkg;

  localparam int unsigned HDR_BYTES    = 14;
  localparam logic [15:0] TYPE_END_GRP = 16'h4547;  // "EG"

  // Byte classes reported on the result channel
  localparam logic [2:0] KIND_HEADER = 3'd0;
  localparam logic [2:0] KIND_JLEN   = 3'd1;
  localparam logic [2:0] KIND_JSON   = 3'd2;
  localparam logic [2:0] KIND_BIN    = 3'd3;
  localparam logic [2:0] KIND_REJ    = 3'd4;

  typedef enum logic [4:0] {
    PH_HEADER = 5'b00001,
    PH_JLEN   = 5'b00010,
    PH_JSON   = 5'b00100,
    PH_BIN    = 5'b01000,
    PH_REJ    = 5'b10000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [31:0] byte_count;
    logic [31:0] grp_num;
    logic [31:0] tgt_num;
    logic [15:0] pkt_type;
    logic [31:0] pay_len;
    logic [31:0] meta_len;
    logic        error;
  } dfr_state_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  data;
    logic [31:0] grp_num;
    logic [31:0] tgt_num;
    logic [15:0] pkt_type;
    logic [31:0] pay_len;
    logic [31:0] meta_len;
    logic        status;
    logic        last;
    logic        end_of_group;
  } dfr_result_t;

endpackage

@@ rtl/core/hybrid_packet_deframer.sv @@
// Top level of the hybrid packet deframer: skid stage, deframing step, result register.
// Depends on hpd_pkg and hpd_step.
//
// Usage:
//   Input channel: one stream byte per beat on in_byte, handshake in_valid/in_stall.
//   Result channel: one result beat per input beat, handshake out_valid/out_stall.
//   Each packet is a 14-byte header (group id, target id, two type characters,
//   payload length, all big-endian) and a payload of a 4-byte json length, json
//   bytes and binary bytes. Every beat carries the byte class and the header
//   registers as they stand after that byte; the last byte of a packet raises
//   out_packet_last with the status, and out_end_of_group for a good "EG" packet.
// Flow and throughput:
//   A byte accepted while the result register is free is presented on the result
//   channel after that edge. One byte per cycle is sustained while out_stall is low;
//   the step into the result register is an increment plus one 33-bit add and compare.
// Stall:
//   While the result register is stalled, one more byte parks in the skid register;
//   in_stall is then raised straight from that register and drops once the skid byte
//   moves into the result register.
// Reset:
//   rst_n low clears all deframing state (header phase, count zero, fields zero)
//   and empties both the skid and the result register.
module hybrid_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_byte_kind,
  output logic [7:0]  out_byte,
  output logic [31:0] out_group_id,
  output logic [31:0] out_target_id,
  output logic [15:0] out_packet_type,
  output logic [31:0] out_payload_length,
  output logic [31:0] out_json_length,
  output logic        out_packet_status,
  output logic        out_packet_last,
  output logic        out_end_of_group
);

  hpd_pkg::dfr_state_t  st_r;
  hpd_pkg::dfr_state_t  st_nxt;
  hpd_pkg::dfr_result_t res;
  hpd_pkg::dfr_result_t res_r;

  logic       skid_valid_r;
  logic [7:0] skid_byte_r;
  logic       out_valid_r;

  logic       in_accept;
  logic       out_free;
  logic       proc_en;
  logic [7:0] proc_byte;

  // the input side only looks at the skid register
  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;

  // the result register can take a new beat when empty or draining this cycle
  assign out_free  = !out_valid_r || !out_stall;

  // the skid byte is older than anything on the input, so process it first
  assign proc_en   = out_free && (skid_valid_r || in_accept);
  assign proc_byte = skid_valid_r ? skid_byte_r : in_byte;

  hpd_step u_step (
    .st     (st_r),
    .data   (proc_byte),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // deframing state: advance once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase      <= hpd_pkg::PH_HEADER;
      st_r.byte_count <= '0;
      st_r.grp_num    <= '0;
      st_r.tgt_num    <= '0;
      st_r.pkt_type   <= '0;
      st_r.pay_len    <= '0;
      st_r.meta_len   <= '0;
      st_r.error      <= 1'b0;
    end else if (proc_en) begin
      st_r <= st_nxt;
    end
  end

  // skid control: park a byte that arrives while the result register is stuck
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_accept && !out_free) begin
        skid_valid_r <= 1'b1;
      end else if (skid_valid_r && out_free) begin
        skid_valid_r <= 1'b0;
      end
      if (proc_en) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers: hold while stalled
  always_ff @(posedge clk) begin
    if (in_accept && !out_free) begin
      skid_byte_r <= in_byte;
    end
    if (proc_en) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_byte_kind      = res_r.byte_kind;
  assign out_byte           = res_r.data;
  assign out_group_id       = res_r.grp_num;
  assign out_target_id      = res_r.tgt_num;
  assign out_packet_type    = res_r.pkt_type;
  assign out_payload_length = res_r.pay_len;
  assign out_json_length    = res_r.meta_len;
  assign out_packet_status  = res_r.status;
  assign out_packet_last    = res_r.last;
  assign out_end_of_group   = res_r.end_of_group;

`ifndef SYNTHESIS
  // a parked byte always sits behind a held result
  a_skid_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid byte held without a pending result");

  // the header byte counter never runs past the header
  a_header_count: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r.phase == hpd_pkg::PH_HEADER) |-> (st_r.byte_count < 32'(hpd_pkg::HDR_BYTES)))
    else $error("header byte count out of range");

  // the last byte of a packet returns the deframer to the header phase
  a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_en && res.last) |=>
      (st_r.phase == hpd_pkg::PH_HEADER) && (st_r.byte_count == 32'd0))
    else $error("packet end did not return to header phase");
`endif

endmodule

@@ rtl/core/hpd_step.sv @@
// Per-byte deframing step: next state and result beat from current state and byte.
// Depends on hpd_pkg.
module hpd_step (
  input  hpd_pkg::dfr_state_t  st,
  input  logic [7:0]           data,
  output hpd_pkg::dfr_state_t  st_nxt,
  output hpd_pkg::dfr_result_t res
);

  logic [31:0] cnt_inc;
  logic [31:0] jlen_new;
  logic [2:0]  kind;
  logic        last;

  always_comb begin
    st_nxt   = st;
    kind     = hpd_pkg::KIND_HEADER;
    last     = 1'b0;
    cnt_inc  = st.byte_count + 32'd1;
    jlen_new = {st.meta_len[23:0], data};

    if (st.phase == hpd_pkg::PH_HEADER) begin
      // first header byte opens a new packet: clear everything
      if (st.byte_count == 32'd0) begin
        st_nxt.grp_num  = '0;
        st_nxt.tgt_num  = '0;
        st_nxt.pkt_type = '0;
        st_nxt.pay_len  = '0;
        st_nxt.meta_len = '0;
        st_nxt.error    = 1'b0;
      end
      if (st.byte_count < 32'd4) begin
        st_nxt.grp_num = {st_nxt.grp_num[23:0], data};
      end else if (st.byte_count < 32'd8) begin
        st_nxt.tgt_num = {st_nxt.tgt_num[23:0], data};
      end else if (st.byte_count < 32'd10) begin
        st_nxt.pkt_type = {st_nxt.pkt_type[7:0], data};
      end else begin
        st_nxt.pay_len = {st_nxt.pay_len[23:0], data};
      end
      st_nxt.byte_count = cnt_inc;
      if (cnt_inc >= 32'(hpd_pkg::HDR_BYTES)) begin
        st_nxt.byte_count = '0;
        if (st_nxt.pay_len < 32'd4) begin
          st_nxt.error = 1'b1;
        end
        if (st_nxt.pay_len == 32'd0) begin
          last = 1'b1;
        end else if (st_nxt.pay_len < 32'd4) begin
          st_nxt.phase = hpd_pkg::PH_REJ;
        end else begin
          st_nxt.phase = hpd_pkg::PH_JLEN;
        end
      end
    end else begin
      st_nxt.byte_count = cnt_inc;
      unique case (st.phase)
        hpd_pkg::PH_JLEN: begin
          kind            = hpd_pkg::KIND_JLEN;
          st_nxt.meta_len = jlen_new;
          if (cnt_inc == 32'd4) begin
            // compare in 33 bits so the +4 cannot wrap
            if (({1'b0, jlen_new} + 33'd4) > {1'b0, st.pay_len}) begin
              st_nxt.error = 1'b1;
              st_nxt.phase = hpd_pkg::PH_REJ;
            end else if (jlen_new == 32'd0) begin
              st_nxt.phase = hpd_pkg::PH_BIN;
            end else begin
              st_nxt.phase = hpd_pkg::PH_JSON;
            end
          end
        end
        hpd_pkg::PH_JSON: begin
          kind = hpd_pkg::KIND_JSON;
          if ({1'b0, cnt_inc} == ({1'b0, st.meta_len} + 33'd4)) begin
            st_nxt.phase = hpd_pkg::PH_BIN;
          end
        end
        hpd_pkg::PH_BIN: begin
          kind = hpd_pkg::KIND_BIN;
        end
        default: begin
          kind = hpd_pkg::KIND_REJ;
        end
      endcase
      if (cnt_inc >= st.pay_len) begin
        last = 1'b1;
      end
    end

    res.byte_kind    = kind;
    res.data         = data;
    res.grp_num      = st_nxt.grp_num;
    res.tgt_num      = st_nxt.tgt_num;
    res.pkt_type     = st_nxt.pkt_type;
    res.pay_len      = st_nxt.pay_len;
    res.meta_len     = st_nxt.meta_len;
    res.status       = st_nxt.error;
    res.last         = last;
    res.end_of_group = last && !st_nxt.error && (st_nxt.pkt_type == hpd_pkg::TYPE_END_GRP);

    // end of packet: return to header
    if (last) begin
      st_nxt.phase      = hpd_pkg::PH_HEADER;
      st_nxt.byte_count = '0;
    end
  end

endmodule

@@ sim/hpd_deframe_checker.sv @@
// Beat checker for the hybrid packet deframer: predicts each result beat from
// the accepted input bytes and compares it with the result channel.
// Depends on hpd_pkg for the result struct, phase codes and byte classes.
module hpd_deframe_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_byte_kind,
  input  logic [7:0]  out_byte,
  input  logic [31:0] out_group_id,
  input  logic [31:0] out_target_id,
  input  logic [15:0] out_packet_type,
  input  logic [31:0] out_payload_length,
  input  logic [31:0] out_json_length,
  input  logic        out_packet_status,
  input  logic        out_packet_last,
  input  logic        out_end_of_group,
  output int unsigned fail_count,
  output int unsigned beats_pending,
  output int unsigned beats_checked,
  output int unsigned packets_seen,
  output int unsigned packets_bad,
  output int unsigned group_ends
);

  // Deframing state of the prediction
  hpd_pkg::phase_t cur_phase;
  logic [31:0]     pos_count;
  logic [31:0]     group_q;
  logic [31:0]     target_q;
  logic [15:0]     type_q;
  logic [31:0]     pay_len_q;
  logic [31:0]     json_len_q;
  logic            bad_q;

  hpd_pkg::dfr_result_t predicted_beats[$];
  hpd_pkg::dfr_result_t want;
  hpd_pkg::dfr_result_t fresh;

  task automatic deframe_byte(input logic [7:0] b, output hpd_pkg::dfr_result_t r);
    logic [2:0]  kind;
    logic        last;
    logic [31:0] idx;
    kind = hpd_pkg::KIND_HEADER;
    last = 1'b0;
    if (cur_phase == hpd_pkg::PH_HEADER) begin
      idx = pos_count;
      if (idx == 0) begin
        group_q    = '0;
        target_q   = '0;
        type_q     = '0;
        pay_len_q  = '0;
        json_len_q = '0;
        bad_q      = 1'b0;
      end
      if (idx < 4)       group_q   = {group_q[23:0], b};
      else if (idx < 8)  target_q  = {target_q[23:0], b};
      else if (idx < 10) type_q    = {type_q[7:0], b};
      else               pay_len_q = {pay_len_q[23:0], b};
      pos_count = idx + 1;
      if (pos_count >= hpd_pkg::HDR_BYTES) begin
        pos_count = '0;
        if (pay_len_q < 4) bad_q = 1'b1;
        if (pay_len_q == 0)     last = 1'b1;
        else if (pay_len_q < 4) cur_phase = hpd_pkg::PH_REJ;
        else                    cur_phase = hpd_pkg::PH_JLEN;
      end
    end else begin
      pos_count = pos_count + 1;
      case (cur_phase)
        hpd_pkg::PH_JLEN: begin
          kind = hpd_pkg::KIND_JLEN;
          json_len_q = {json_len_q[23:0], b};
          if (pos_count == 4) begin
            // compare in 33 bits so a huge json length cannot wrap past the check
            if ({1'b0, json_len_q} + 33'd4 > {1'b0, pay_len_q}) begin
              bad_q = 1'b1;
              cur_phase = hpd_pkg::PH_REJ;
            end else if (json_len_q == 0) begin
              cur_phase = hpd_pkg::PH_BIN;
            end else begin
              cur_phase = hpd_pkg::PH_JSON;
            end
          end
        end
        hpd_pkg::PH_JSON: begin
          kind = hpd_pkg::KIND_JSON;
          if ({1'b0, pos_count} == {1'b0, json_len_q} + 33'd4) cur_phase = hpd_pkg::PH_BIN;
        end
        hpd_pkg::PH_BIN: kind = hpd_pkg::KIND_BIN;
        default:         kind = hpd_pkg::KIND_REJ;
      endcase
      if (pos_count >= pay_len_q) last = 1'b1;
    end
    r.byte_kind    = kind;
    r.data         = b;
    r.grp_num      = group_q;
    r.tgt_num      = target_q;
    r.pkt_type     = type_q;
    r.pay_len      = pay_len_q;
    r.meta_len     = json_len_q;
    r.status       = bad_q;
    r.last         = last;
    r.end_of_group = last && !bad_q && (type_q == hpd_pkg::TYPE_END_GRP);
    if (last) begin
      cur_phase = hpd_pkg::PH_HEADER;
      pos_count = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      cur_phase     = hpd_pkg::PH_HEADER;
      pos_count     = '0;
      group_q       = '0;
      target_q      = '0;
      type_q        = '0;
      pay_len_q     = '0;
      json_len_q    = '0;
      bad_q         = 1'b0;
      fail_count    = 0;
      beats_checked = 0;
      packets_seen  = 0;
      packets_bad   = 0;
      group_ends    = 0;
      predicted_beats.delete();
    end else begin
      // retire first so a beat can never match a byte taken at the same edge
      if (out_valid && !out_stall) begin
        if (predicted_beats.size() == 0) begin
          fail_count++;
          $display("%0t: result beat with no byte pending, expected none, actual byte %0h",
                   $time, out_byte);
        end else begin
          want = predicted_beats.pop_front();
          check_field("byte_kind", 32'(want.byte_kind), 32'(out_byte_kind));
          check_field("out_byte", 32'(want.data), 32'(out_byte));
          check_field("out_group_id", want.grp_num, out_group_id);
          check_field("out_target_id", want.tgt_num, out_target_id);
          check_field("packet_type", 32'(want.pkt_type), 32'(out_packet_type));
          check_field("payload_length", want.pay_len, out_payload_length);
          check_field("json_length", want.meta_len, out_json_length);
          check_field("packet_status", 32'(want.status), 32'(out_packet_status));
          check_field("packet_last", 32'(want.last), 32'(out_packet_last));
          check_field("end_of_group", 32'(want.end_of_group), 32'(out_end_of_group));
          beats_checked++;
          if (want.last) begin
            packets_seen++;
            if (want.status) packets_bad++;
            if (want.end_of_group) group_ends++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        deframe_byte(in_byte, fresh);
        predicted_beats.insert(predicted_beats.size(), fresh);
      end
    end
    beats_pending <= predicted_beats.size();
  end

endmodule

@@ sim/tb_hybrid_packet_deframer.sv @@
// Testbench top for the hybrid packet deframer: builds packet byte streams,
// drives both handshakes with random idling and gives the verdict.
// Depends on hpd_pkg, hybrid_packet_deframer and hpd_deframe_checker.
module tb_hybrid_packet_deframer;

  localparam int unsigned QUIET_LIMIT = 1000;  // cycles with no beat on either side
  localparam int unsigned HOLD_CYCLES = 64;    // long receiver hold-off
  localparam int unsigned PHASE_BYTES = 480;   // random bytes per idling phase

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_byte_kind;
  logic [7:0]  out_byte;
  logic [31:0] out_group_id;
  logic [31:0] out_target_id;
  logic [15:0] out_packet_type;
  logic [31:0] out_payload_length;
  logic [31:0] out_json_length;
  logic        out_packet_status;
  logic        out_packet_last;
  logic        out_end_of_group;

  int unsigned fail_count;
  int unsigned beats_pending;
  int unsigned beats_checked;
  int unsigned packets_seen;
  int unsigned packets_bad;
  int unsigned group_ends;

  // Idling odds in percent, one per side, changed between phases
  int unsigned send_idle_pct = 11;
  int unsigned recv_idle_pct = 58;

  logic        hold_req = 1'b0;
  logic        hold_taken;
  int unsigned hold_left;
  int unsigned quiet_cycles;
  int unsigned bytes_sent = 0;

  // Byte stream waiting to be offered on the input channel
  logic [7:0] stream_q[$];

  always #5 clk = ~clk;

  hybrid_packet_deframer dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_kind      (out_byte_kind),
    .out_byte           (out_byte),
    .out_group_id       (out_group_id),
    .out_target_id      (out_target_id),
    .out_packet_type    (out_packet_type),
    .out_payload_length (out_payload_length),
    .out_json_length    (out_json_length),
    .out_packet_status  (out_packet_status),
    .out_packet_last    (out_packet_last),
    .out_end_of_group   (out_end_of_group)
  );

  hpd_deframe_checker deframe_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_byte_kind      (out_byte_kind),
    .out_byte           (out_byte),
    .out_group_id       (out_group_id),
    .out_target_id      (out_target_id),
    .out_packet_type    (out_packet_type),
    .out_payload_length (out_payload_length),
    .out_json_length    (out_json_length),
    .out_packet_status  (out_packet_status),
    .out_packet_last    (out_packet_last),
    .out_end_of_group   (out_end_of_group),
    .fail_count         (fail_count),
    .beats_pending      (beats_pending),
    .beats_checked      (beats_checked),
    .packets_seen       (packets_seen),
    .packets_bad        (packets_bad),
    .group_ends         (group_ends)
  );

  // Receiver: random stalls, plus one long hold-off once the sender asks for it.
  // The hold is counted here so the sender keeps offering bytes meanwhile and
  // the skid stage fills up and pushes back on in_stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken) begin
      out_stall  <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      hold_taken <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Append the low bytes of a big-endian number
  task automatic push_word(input logic [31:0] w, input int unsigned nbytes);
    int unsigned i;
    for (i = nbytes; i > 0; i--) stream_q.insert(stream_q.size(), w[8*i-1 -: 8]);
  endtask

  // Append one packet. A raw payload keeps the length field random too, which
  // makes a broken packet that still leaves the framing in step.
  task automatic queue_packet(input logic [31:0] grp, input logic [31:0] tgt,
                              input logic [15:0] typ, input logic [31:0] plen,
                              input logic [31:0] jlen, input int unsigned pay_bytes,
                              input bit raw);
    int unsigned i;
    push_word(grp, 4);
    push_word(tgt, 4);
    push_word({16'h0, typ}, 2);
    push_word(plen, 4);
    for (i = 0; i < pay_bytes; i++) begin
      if (!raw && plen >= 4 && i < 4) stream_q.insert(stream_q.size(), jlen[31-8*i -: 8]);
      else                            stream_q.insert(stream_q.size(), 8'($urandom));
    end
  endtask

  task automatic random_packet();
    logic [31:0] grp;
    logic [31:0] tgt;
    logic [31:0] plen;
    logic [31:0] jlen;
    logic [15:0] typ;
    int unsigned pick;
    bit          raw;
    grp = $urandom;
    tgt = $urandom;
    pick = $urandom_range(9);
    if (pick == 0) grp = '0;
    else if (pick == 1) grp = '1;
    pick = $urandom_range(9);
    if (pick == 0) tgt = '0;
    else if (pick == 1) tgt = '1;
    // often EG, some one bit off EG, the rest anything
    pick = $urandom_range(99);
    if (pick < 40)      typ = hpd_pkg::TYPE_END_GRP;
    else if (pick < 50) typ = hpd_pkg::TYPE_END_GRP ^ (16'h1 << $urandom_range(15));
    else                typ = 16'($urandom);
    // keep payloads short, a few long ones
    pick = $urandom_range(99);
    if (pick < 5)       plen = 0;
    else if (pick < 12) plen = $urandom_range(1, 3);
    else if (pick < 85) plen = $urandom_range(4, 32);
    else if (pick < 97) plen = $urandom_range(33, 120);
    else                plen = $urandom_range(121, 400);
    pick = $urandom_range(99);
    if (plen < 4)       jlen = '0;
    else if (pick < 15) jlen = '0;
    else if (pick < 75) jlen = $urandom_range(0, plen - 4);
    else if (pick < 90) jlen = $urandom_range(plen - 3, plen + 16);
    else                jlen = $urandom;
    raw = ($urandom_range(99) < 8);
    queue_packet(grp, tgt, typ, plen, jlen, plen, raw);
  endtask

  // Offer every queued byte; gaps are random, valid holds until accepted
  task automatic send_stream();
    logic [7:0] b;
    while (stream_q.size() != 0) begin
      b = stream_q.pop_front();
      while ($urandom_range(99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_byte  <= b;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
    in_valid <= 1'b0;
  endtask

  // Pause the sender until every predicted beat has come back
  task automatic drain();
    @(posedge clk);
    while (beats_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int unsigned ph;
    int unsigned goal;
    int unsigned phase_start;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed packets
    // empty payload: header's last byte ends the packet, flagged bad, no group end
    queue_packet(32'h0000_0000, 32'hFFFF_FFFF, hpd_pkg::TYPE_END_GRP, 32'd0, 32'd0, 0, 1'b0);
    // short payloads: every payload byte rejected
    queue_packet(32'hFFFF_FFFF, 32'h0000_0000, 16'hFFFF, 32'd1, 32'd0, 1, 1'b0);
    queue_packet(32'h0102_0304, 32'h8000_0001, 16'h0000, 32'd3, 32'd0, 3, 1'b0);
    // zero json length, no binary: packet ends on the length field
    queue_packet(32'h1234_5678, 32'h9ABC_DEF0, hpd_pkg::TYPE_END_GRP, 32'd4, 32'd0, 4, 1'b0);
    // json fills the payload exactly
    queue_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF, hpd_pkg::TYPE_END_GRP, 32'd7, 32'd3, 7, 1'b0);
    // zero json length, binary right after the length field
    queue_packet(32'h0000_0001, 32'h0000_0002, 16'h4142, 32'd9, 32'd0, 9, 1'b0);
    // json length one too large
    queue_packet(32'hA5A5_A5A5, 32'h5A5A_5A5A, hpd_pkg::TYPE_END_GRP, 32'd10, 32'd7, 10,
                 1'b0);
    // json length that would wrap a 32-bit sum and slip past the check
    queue_packet(32'h7FFF_FFFF, 32'h8000_0000, hpd_pkg::TYPE_END_GRP, 32'd12, 32'hFFFF_FFFE,
                 12, 1'b0);
    send_stream();
    drain();

    // Random packets in three idling phases: sender light / receiver heavy,
    // then swapped, then no idling at all
    for (ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 11 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 11 : 0;
      phase_start = bytes_sent;
      goal = bytes_sent + PHASE_BYTES;
      while (bytes_sent < goal) begin
        random_packet();
        // start the long receiver hold-off partway through the first phase
        if (ph == 0 && bytes_sent >= phase_start + 100) hold_req <= 1'b1;
        send_stream();
      end
      drain();
    end

    // Huge payload length with an all-ones json length: rejected after the
    // length field; the packet never completes and the run stops inside it
    queue_packet($urandom, $urandom, hpd_pkg::TYPE_END_GRP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9,
                 1'b0);
    send_stream();
    drain();

    $display("Run covered %0d bytes and %0d checked beats: %0d packets closed,", bytes_sent,
             beats_checked, packets_seen);
    $display("%0d of them with decode errors and %0d ending a group.", packets_bad,
             group_ends);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
